@@ design/ctb_pkg.sv @@
package ctb_pkg;

  // Bank size and derived widths
  localparam int NUM_TIMERS = 16;
  localparam int IDX_W      = $clog2(NUM_TIMERS);
  localparam int CNT_W      = $clog2(NUM_TIMERS + 1);

  // Field widths
  localparam int OP_W      = 3;
  localparam int SLOT_W    = 4;
  localparam int DELAY_W   = 24;
  localparam int REM_W     = 26;
  localparam int STEP_W    = 16;
  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 8;

  localparam logic [STEP_W-1:0] TICK_STEP_RESET = 16'd1000;

  // Command codes
  localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD     = 3'd1;
  localparam logic [OP_W-1:0] OP_SET     = 3'd2;
  localparam logic [OP_W-1:0] OP_PAUSE   = 3'd3;
  localparam logic [OP_W-1:0] OP_UNPAUSE = 3'd4;
  localparam logic [OP_W-1:0] OP_RELOAD  = 3'd5;
  localparam logic [OP_W-1:0] OP_EXPIRE  = 3'd6;
  localparam logic [OP_W-1:0] OP_KILL    = 3'd7;

  // One expiry event handed to the output stage
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
    logic              reloaded;
    logic              last;
  } event_push_t;

endpackage

@@ design/ctb_ram.sv @@
module ctb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/ctb_out.sv @@
module ctb_out (
  input  logic                             clk,
  input  logic                             rst,
  input  ctb_pkg::event_push_t             push,
  output logic                             free,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [ctb_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                             m_axis_tlast
);

  logic [ctb_pkg::SLOT_W-1:0] slot;
  logic                       reloaded;

  // Register can take a new event when empty or being drained this cycle
  assign free = !m_axis_tvalid || m_axis_tready;

  // Hold valid until transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (push.valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Load payload
  always_ff @(posedge clk) begin
    if (push.valid) begin
      slot         <= push.slot;
      reloaded     <= push.reloaded;
      m_axis_tlast <= push.last;
    end
  end

  assign m_axis_tdata = {3'b000, reloaded, slot};

endmodule

@@ design/countdown_timer_bank.sv @@
// Bank of 16 countdown timer slots driven by a command stream. Start values
// and remaining counts live in two single-port-read memories; active, paused
// and reload flags sit in flip-flops. Add, set delay, pause, unpause, expire
// now and kill complete from the idle state; reload also passes a reload
// state (memory read, then write). A tick scan issues the first read, then
// evaluates each slot in turn and writes it back, then flushes the final
// event marked with tlast. The scan stalls while the output register is full
// and another event must move out. Events leave in ascending slot order.
// Write tick_step through cfg only while no tick is in progress.
module countdown_timer_bank (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [3:0] slot, [27:4] delay, [28] auto_reload, [31:29] zero
  input  logic [ctb_pkg::IN_DATA_W-1:0]        s_axis_tdata,
  // [2:0] opcode
  input  logic [ctb_pkg::OP_W-1:0]             s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [3:0] expired_slot, [4] reloaded, [7:5] zero
  output logic [ctb_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  output logic                                 m_axis_tlast,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ctb_pkg::STEP_W-1:0]           cfg_data
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_RELOAD = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_DRAIN  = 2'd3;

  logic [1:0] state;
  logic [ctb_pkg::STEP_W-1:0] tick_step;

  logic [ctb_pkg::NUM_TIMERS-1:0] active;
  logic [ctb_pkg::NUM_TIMERS-1:0] paused;
  logic [ctb_pkg::NUM_TIMERS-1:0] reload_f;

  logic [ctb_pkg::IDX_W-1:0] cmd_idx;
  logic [ctb_pkg::CNT_W-1:0] cnt;
  logic                      s1_valid;
  logic [ctb_pkg::IDX_W-1:0] s1_idx;

  logic                       pend_valid;
  logic [ctb_pkg::SLOT_W-1:0] pend_slot;
  logic                       pend_reloaded;

  // Input fields
  logic [ctb_pkg::OP_W-1:0]    opcode;
  logic [ctb_pkg::SLOT_W-1:0]  slot;
  logic [ctb_pkg::DELAY_W-1:0] delay;
  logic                        auto_reload;
  logic [ctb_pkg::IDX_W-1:0]   slot_idx;
  logic                        slot_ok;
  logic                        slot_act;
  logic                        accept;

  // Memory ports
  logic                        rd_en;
  logic [ctb_pkg::IDX_W-1:0]   rd_addr;
  logic [ctb_pkg::DELAY_W-1:0] start_rd;
  logic [ctb_pkg::REM_W-1:0]   rem_rd;
  logic                        start_we;
  logic [ctb_pkg::DELAY_W-1:0] start_wd;
  logic                        rem_we;
  logic [ctb_pkg::IDX_W-1:0]   rem_wa;
  logic [ctb_pkg::REM_W-1:0]   rem_wd;

  // Scan datapath
  logic                            s1_act;
  logic signed [ctb_pkg::REM_W-1:0] s1_rem;
  logic                            s1_exp;
  logic                            push_prev;
  logic                            advance;
  logic                            more;
  logic                            out_free;
  ctb_pkg::event_push_t            push;

  assign opcode      = s_axis_tuser;
  assign slot        = s_axis_tdata[3:0];
  assign delay       = s_axis_tdata[27:4];
  assign auto_reload = s_axis_tdata[28];
  assign slot_idx    = ctb_pkg::IDX_W'(slot);
  assign slot_ok     = (32'(slot) < ctb_pkg::NUM_TIMERS);
  assign slot_act    = slot_ok && active[slot_idx];

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  // Tick step register
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_step <= ctb_pkg::TICK_STEP_RESET;
    end else if (cfg_valid) begin
      tick_step <= cfg_data;
    end
  end

  // Slot under evaluation in the scan
  assign s1_act = active[s1_idx];
  assign s1_rem = paused[s1_idx] ? $signed(rem_rd)
                                 : $signed(rem_rd) - $signed({10'b0, tick_step});
  assign s1_exp = s1_valid && s1_act && (s1_rem[ctb_pkg::REM_W-1] || (s1_rem == '0));
  assign push_prev = s1_exp && pend_valid;
  assign advance   = !(push_prev && !out_free);
  assign more      = (cnt < ctb_pkg::CNT_W'(ctb_pkg::NUM_TIMERS));

  // Memory read: reload command or next scan slot
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cnt[ctb_pkg::IDX_W-1:0];
    if (state == ST_IDLE) begin
      rd_en   = accept && (opcode == ctb_pkg::OP_RELOAD) && slot_act;
      rd_addr = slot_idx;
    end else if (state == ST_SCAN) begin
      rd_en = advance && more;
    end
  end

  // Memory writes
  always_comb begin
    start_we = 1'b0;
    start_wd = delay;
    rem_we   = 1'b0;
    rem_wa   = slot_idx;
    rem_wd   = {2'b00, delay};
    unique case (state)
      ST_IDLE: begin
        if (accept && slot_ok) begin
          start_we = (opcode == ctb_pkg::OP_ADD) ||
                     ((opcode == ctb_pkg::OP_SET) && slot_act);
          rem_we   = (opcode == ctb_pkg::OP_ADD) ||
                     (((opcode == ctb_pkg::OP_SET) || (opcode == ctb_pkg::OP_EXPIRE))
                      && slot_act);
          if (opcode == ctb_pkg::OP_EXPIRE) begin
            rem_wd = '0;
          end
        end
      end
      ST_RELOAD: begin
        rem_we = 1'b1;
        rem_wa = cmd_idx;
        rem_wd = {2'b00, start_rd};
      end
      ST_SCAN: begin
        rem_we = advance && s1_valid && s1_act;
        rem_wa = s1_idx;
        rem_wd = (s1_exp && reload_f[s1_idx]) ? {2'b00, start_rd} : s1_rem;
      end
      default: begin
      end
    endcase
  end

  // Event hand-off: previous pending event during scan, final one at drain
  always_comb begin
    push.valid    = 1'b0;
    push.slot     = pend_slot;
    push.reloaded = pend_reloaded;
    push.last     = (state == ST_DRAIN);
    if (state == ST_SCAN) begin
      push.valid = push_prev && advance;
    end else if (state == ST_DRAIN) begin
      push.valid = pend_valid && out_free;
    end
  end

  // Control state, flags and scan pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      active     <= '0;
      paused     <= '0;
      reload_f   <= '0;
      s1_valid   <= 1'b0;
      pend_valid <= 1'b0;
      cnt        <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            cmd_idx <= slot_idx;
            if (opcode == ctb_pkg::OP_TICK) begin
              state    <= ST_SCAN;
              cnt      <= '0;
              s1_valid <= 1'b0;
            end else if (opcode == ctb_pkg::OP_ADD) begin
              if (slot_ok) begin
                active[slot_idx]   <= 1'b1;
                paused[slot_idx]   <= 1'b0;
                reload_f[slot_idx] <= auto_reload;
              end
            end else if (slot_act) begin
              unique case (opcode)
                ctb_pkg::OP_PAUSE:   paused[slot_idx] <= 1'b1;
                ctb_pkg::OP_UNPAUSE: paused[slot_idx] <= 1'b0;
                ctb_pkg::OP_RELOAD:  state <= ST_RELOAD;
                ctb_pkg::OP_KILL: begin
                  active[slot_idx]   <= 1'b0;
                  paused[slot_idx]   <= 1'b0;
                  reload_f[slot_idx] <= 1'b0;
                end
                default: begin
                end
              endcase
            end
          end
        end
        ST_RELOAD: begin
          state <= ST_IDLE;
        end
        ST_SCAN: begin
          if (advance) begin
            // Retire the slot held in stage s1
            if (s1_exp) begin
              pend_valid    <= 1'b1;
              pend_slot     <= ctb_pkg::SLOT_W'(s1_idx);
              pend_reloaded <= reload_f[s1_idx];
              if (!reload_f[s1_idx]) begin
                active[s1_idx] <= 1'b0;
                paused[s1_idx] <= 1'b0;
              end
            end
            // Issue the next slot
            if (more) begin
              s1_valid <= 1'b1;
              s1_idx   <= cnt[ctb_pkg::IDX_W-1:0];
              cnt      <= cnt + 1'b1;
            end else begin
              s1_valid <= 1'b0;
              state    <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (!pend_valid) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  ctb_ram #(
    .WIDTH (ctb_pkg::DELAY_W),
    .DEPTH (ctb_pkg::NUM_TIMERS)
  ) u_start_ram (
    .clk   (clk),
    .we    (start_we),
    .waddr (slot_idx),
    .wdata (start_wd),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (start_rd)
  );

  ctb_ram #(
    .WIDTH (ctb_pkg::REM_W),
    .DEPTH (ctb_pkg::NUM_TIMERS)
  ) u_rem_ram (
    .clk   (clk),
    .we    (rem_we),
    .waddr (rem_wa),
    .wdata (rem_wd),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rem_rd)
  );

  ctb_out u_out (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .free          (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

@@ design/ctb_checker.sv @@
module ctb_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 s_axis_tvalid,
  input logic                                 s_axis_tready,
  input logic [ctb_pkg::OP_W-1:0]             s_axis_tuser,
  input logic                                 m_axis_tvalid,
  input logic                                 m_axis_tready,
  input logic [ctb_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  input logic                                 m_axis_tlast,
  input logic                                 cfg_valid,
  input logic                                 cfg_ready
);

  // Come out of reset ready for commands with no event pending
  a_reset_clear: assert property (@(posedge clk)
    rst |=> (s_axis_tready && !m_axis_tvalid))
    else $error("not idle after reset");

  // A tick transfer starts a scan, so no command is taken next cycle
  a_tick_blocks: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == ctb_pkg::OP_TICK))
      |=> !s_axis_tready)
    else $error("command taken during tick scan");

  // Configuration writes are never refused
  a_cfg_taken: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

  // Stalled event stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("event dropped while stalled");

  // Stalled event keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("event changed while stalled");

endmodule

bind countdown_timer_bank ctb_checker u_ctb_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .cfg_valid     (cfg_valid),
  .cfg_ready     (cfg_ready)
);

@@ tb/countdown_timer_bank_test.sv @@
module countdown_timer_bank_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ctb_pkg::*;

  localparam int DRAIN_CYCLES   = 2 * NUM_TIMERS + 8;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int END_LIMIT      = 20000;
  localparam int DIR_ROWS       = 25;
  localparam int RAND_PER_PHASE = 20;

  // One expiry event as seen on the output stream
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              reloaded;
    logic              last;
  } expiry_t;

  // Directed row: command plus an optional hand-written event list
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [SLOT_W-1:0]  slot;
    logic [DELAY_W-1:0] dly;
    logic               ar;
    logic               typed;
    logic [1:0]         n_ev;
    logic [SLOT_W-1:0]  s0;
    logic               r0;
    logic [SLOT_W-1:0]  s1;
    logic               r1;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [OP_W-1:0]       s_axis_tuser  = OP_TICK;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [STEP_W-1:0]     cfg_data  = '0;

  // Shadow copy of the timer bank
  logic                 slot_active [NUM_TIMERS];
  logic                 slot_paused [NUM_TIMERS];
  logic                 slot_reload [NUM_TIMERS];
  logic [DELAY_W-1:0]   slot_start  [NUM_TIMERS];
  int                   slot_rem    [NUM_TIMERS];
  logic [STEP_W-1:0]    step_ms;

  expiry_t tick_events[$];
  expiry_t pending_expiries[$];

  int errors      = 0;
  int idle_cycles = 0;
  int burst_left  = 0;
  int hold_req    = 0;
  int hold_done   = 0;
  int rx_mode     = 0;
  int rx_left     = 0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{OP_TICK,    4'd0,  24'd0,        1'b0, 1'b1, 2'd0, 4'd0,  1'b0, 4'd0,  1'b0},
    '{OP_ADD,     4'd0,  24'd0,        1'b0, 1'b0, 2'd0, 4'd0,  1'b0, 4'd0,  1'b0},
    '{OP_ADD,     4'd15, 24'hFFFFFF,   1'b1, 1'b0, 2'd0, 4'd0,  1'b0, 4'd0,  1'b0},
    '{OP_TICK,    4'd0,  24'd0,        1'b0, 1'b1, 2'd1, 4'd0,  1'b0, 4'd0,  1'b0},
    '{OP_ADD,     4'd3,  24'd1000,     1'b1, 1'b0, 2'd0, 4'd0,  1'b0, 4'd0,  1'b0},
    '{OP_ADD,     4'd7,  24'd500,      1'b0, 1'b0, 2'd0, 4'd0,  1'b0, 4'd0,  1'b0},
    '{OP_PAUSE,   4'd7,  24'd0,        1'b0, 1'b0, 2'd0, 4'd0,  1'b0, 4'd0,  1'b0},
    '{OP_TICK,    4'd0,  24'd0,        1'b0, 1'b1, 2'd1, 4'd3,  1'b1, 4'd0,  1'b0},
    '{OP_EXPIRE,  4'd7,  24'd0,        1'b0, 1'b0, 2'd0, 4'd0,  1'b0, 4'd0,  1'b0},
    '{OP_TICK,    4'd0,  24'd0,        1'b0, 1'b1, 2'd2, 4'd3,  1'b1, 4'd7,  1'b0},
    '{OP_KILL,    4'd3,  24'd0,        1'b0, 1'b0, 2'd0, 4'd0,  1'b0, 4'd0,  1'b0},
    '{OP_TICK,    4'd0,  24'd0,        1'b0, 1'b1, 2'd0, 4'd0,  1'b0, 4'd0,  1'b0},
    '{OP_PAUSE,   4'd5,  24'd0,        1'b0, 1'b0, 2'd0, 4'd0,  1'b0, 4'd0,  1'b0},
    '{OP_SET,     4'd15, 24'd2000,     1'b0, 1'b0, 2'd0, 4'd0,  1'b0, 4'd0,  1'b0},
    '{OP_TICK,    4'd0,  24'd0,        1'b0, 1'b1, 2'd0, 4'd0,  1'b0, 4'd0,  1'b0},
    '{OP_RELOAD,  4'd15, 24'd0,        1'b0, 1'b0, 2'd0, 4'd0,  1'b0, 4'd0,  1'b0},
    '{OP_TICK,    4'd0,  24'd0,        1'b0, 1'b0, 2'd0, 4'd0,  1'b0, 4'd0,  1'b0},
    '{OP_TICK,    4'd0,  24'd0,        1'b0, 1'b1, 2'd1, 4'd15, 1'b1, 4'd0,  1'b0},
    '{OP_ADD,     4'd9,  24'd100,      1'b1, 1'b0, 2'd0, 4'd0,  1'b0, 4'd0,  1'b0},
    '{OP_PAUSE,   4'd9,  24'd0,        1'b0, 1'b0, 2'd0, 4'd0,  1'b0, 4'd0,  1'b0},
    '{OP_ADD,     4'd9,  24'd100,      1'b0, 1'b0, 2'd0, 4'd0,  1'b0, 4'd0,  1'b0},
    '{OP_UNPAUSE, 4'd15, 24'd0,        1'b0, 1'b0, 2'd0, 4'd0,  1'b0, 4'd0,  1'b0},
    '{OP_EXPIRE,  4'd2,  24'd0,        1'b0, 1'b0, 2'd0, 4'd0,  1'b0, 4'd0,  1'b0},
    '{OP_KILL,    4'd12, 24'd0,        1'b0, 1'b0, 2'd0, 4'd0,  1'b0, 4'd0,  1'b0},
    '{OP_TICK,    4'd0,  24'd0,        1'b0, 1'b1, 2'd1, 4'd9,  1'b0, 4'd0,  1'b0}
  };

  countdown_timer_bank u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // Advance the shadow bank by one command; tick events land in tick_events
  task automatic apply_command(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                               input logic [DELAY_W-1:0] dly, input logic ar);
    expiry_t ev;
    tick_events.delete();
    if (op == OP_TICK) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        if (slot_active[i]) begin
          if (!slot_paused[i]) slot_rem[i] -= int'(step_ms);
          if (slot_rem[i] <= 0) begin
            ev.slot     = SLOT_W'(i);
            ev.reloaded = slot_reload[i];
            ev.last     = 1'b0;
            tick_events.push_back(ev);
            if (slot_reload[i]) begin
              slot_rem[i] = int'(slot_start[i]);
            end else begin
              slot_active[i] = 1'b0;
              slot_paused[i] = 1'b0;
            end
          end
        end
      end
      if (tick_events.size() > 0) tick_events[tick_events.size()-1].last = 1'b1;
    end else if (op == OP_ADD) begin
      slot_active[slot] = 1'b1;
      slot_paused[slot] = 1'b0;
      slot_reload[slot] = ar;
      slot_start[slot]  = dly;
      slot_rem[slot]    = int'(dly);
    end else if (slot_active[slot]) begin
      case (op)
        OP_SET: begin
          slot_start[slot] = dly;
          slot_rem[slot]   = int'(dly);
        end
        OP_PAUSE:   slot_paused[slot] = 1'b1;
        OP_UNPAUSE: slot_paused[slot] = 1'b0;
        OP_RELOAD:  slot_rem[slot] = int'(slot_start[slot]);
        OP_EXPIRE:  slot_rem[slot] = 0;
        default: begin
          slot_active[slot] = 1'b0;
          slot_paused[slot] = 1'b0;
          slot_reload[slot] = 1'b0;
        end
      endcase
    end
  endtask

  // Offer one command, with burst/gap shaping, and hold until the transfer
  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                          input logic [DELAY_W-1:0] dly, input logic ar);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, ar, dly, slot};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  // Send a command and queue whatever the shadow bank predicts for it
  task automatic issue_cmd(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                           input logic [DELAY_W-1:0] dly, input logic ar);
    send_cmd(op, slot, dly, ar);
    apply_command(op, slot, dly, ar);
    foreach (tick_events[i]) pending_expiries.push_back(tick_events[i]);
  endtask

  // Drop valid, wait for every queued event, then let the scan settle
  task automatic wait_drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_expiries.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_step(input logic [STEP_W-1:0] val);
    wait_drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    step_ms = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Delays mostly a few steps long, with zero, full scale and raw random mixed in
  function automatic logic [DELAY_W-1:0] pick_delay();
    int d;
    int unit;
    unit = (step_ms == 0) ? 1000 : int'(step_ms);
    case ($urandom_range(0, 9))
      0:       d = 0;
      1:       d = int'($urandom & 32'h00FF_FFFF);
      2:       d = 24'hFFFFFF;
      default: d = unit * $urandom_range(0, 4) + $urandom_range(0, unit);
    endcase
    if (d > 24'hFFFFFF) d = 24'hFFFFFF;
    return DELAY_W'(d);
  endfunction

  // Prefer slots that are running so that most commands take effect
  function automatic logic [SLOT_W-1:0] pick_slot();
    logic [SLOT_W-1:0] s;
    s = SLOT_W'($urandom_range(0, NUM_TIMERS - 1));
    if ($urandom_range(0, 9) < 7) begin
      for (int k = 0; k < NUM_TIMERS; k++) begin
        if (!slot_active[s]) s = SLOT_W'($urandom_range(0, NUM_TIMERS - 1));
      end
    end
    return s;
  endfunction

  task automatic random_cmds(input int count);
    int r;
    logic [OP_W-1:0] op;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if      (r < 25) op = OP_TICK;
      else if (r < 50) op = OP_ADD;
      else if (r < 58) op = OP_SET;
      else if (r < 66) op = OP_PAUSE;
      else if (r < 74) op = OP_UNPAUSE;
      else if (r < 82) op = OP_RELOAD;
      else if (r < 90) op = OP_EXPIRE;
      else             op = OP_KILL;
      issue_cmd(op, pick_slot(), pick_delay(), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic check_expiry(input logic [OUT_DATA_W-1:0] data, input logic last);
    expiry_t want;
    if (pending_expiries.size() == 0) begin
      report_mismatch($sformatf("unexpected expiry of slot %0d", data[SLOT_W-1:0]));
      return;
    end
    want = pending_expiries.pop_front();
    if (data[SLOT_W-1:0] !== want.slot)
      report_mismatch($sformatf("expired_slot %0d, want %0d", data[SLOT_W-1:0], want.slot));
    if (data[SLOT_W] !== want.reloaded)
      report_mismatch($sformatf("slot %0d reloaded %b, want %b", want.slot, data[SLOT_W],
                                want.reloaded));
    if (last !== want.last)
      report_mismatch($sformatf("slot %0d last %b, want %b", want.slot, last, want.last));
  endtask

  // Check output transfers and watch for a stalled run
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) check_expiry(m_axis_tdata, m_axis_tlast);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("countdown_timer_bank_test failed");
        $finish;
      end
    end
  end

  // Receiver: random stall patterns, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req != hold_done) begin
        hold_done = hold_req;
        m_axis_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
      end
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(20, 80);
      end
      rx_left--;
      case (rx_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= ~m_axis_tready;
      endcase
    end
  end

  initial begin
    logic [STEP_W-1:0] phase_steps [4];
    expiry_t ev;
    int waited;

    for (int i = 0; i < NUM_TIMERS; i++) begin
      slot_active[i] = 1'b0;
      slot_paused[i] = 1'b0;
      slot_reload[i] = 1'b0;
      slot_start[i]  = '0;
      slot_rem[i]    = 0;
    end
    step_ms = TICK_STEP_RESET;

    // Hold reset, then release it on a falling clock edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table under the reset step
    for (int k = 0; k < DIR_ROWS; k++) begin
      send_cmd(dir_rows[k].op, dir_rows[k].slot, dir_rows[k].dly, dir_rows[k].ar);
      apply_command(dir_rows[k].op, dir_rows[k].slot, dir_rows[k].dly, dir_rows[k].ar);
      if (dir_rows[k].typed) begin
        for (int e = 0; e < int'(dir_rows[k].n_ev); e++) begin
          ev.slot     = (e == 0) ? dir_rows[k].s0 : dir_rows[k].s1;
          ev.reloaded = (e == 0) ? dir_rows[k].r0 : dir_rows[k].r1;
          ev.last     = (e == int'(dir_rows[k].n_ev) - 1);
          pending_expiries.push_back(ev);
        end
      end else begin
        foreach (tick_events[i]) pending_expiries.push_back(tick_events[i]);
      end
    end

    // Fill the bank with zero-delay reloading slots, then tick into a held-off receiver
    write_step(16'hFFFF);
    for (int s = 0; s < NUM_TIMERS; s++) issue_cmd(OP_ADD, SLOT_W'(s), '0, 1'b1);
    hold_req++;
    repeat (4) issue_cmd(OP_TICK, '0, '0, 1'b0);
    wait_drain();
    for (int s = 0; s < NUM_TIMERS; s++) issue_cmd(OP_KILL, SLOT_W'(s), '0, 1'b0);
    random_cmds(RAND_PER_PHASE);

    // Random phases under other step settings
    phase_steps[0] = 16'd1;
    phase_steps[1] = 16'd0;
    phase_steps[2] = STEP_W'($urandom_range(1, 65535));
    phase_steps[3] = STEP_W'($urandom_range(1, 4000));
    for (int p = 0; p < 4; p++) begin
      write_step(phase_steps[p]);
      random_cmds(RAND_PER_PHASE);
    end

    // Let the last events drain
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (pending_expiries.size() != 0 && waited < END_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_expiries.size() != 0)
      report_mismatch($sformatf("%0d expiry events never arrived", pending_expiries.size()));

    if (errors == 0) begin
      $display("countdown_timer_bank_test passed");
    end else begin
      $display("countdown_timer_bank_test failed");
    end
    $finish;
  end

endmodule
